@@ rtl/core/upr_pkg.sv @@
// ----------------------------------------------------------------------------
// upr_pkg: shared types and constants for the UDP port receive queues
// Item and result words, operation and status codes, the command word that
// travels from the front end to the back end, and back-end states.
// ----------------------------------------------------------------------------
package upr_pkg;

  localparam int unsigned HANDLE_W = 12;

  // Length checks on a received datagram
  localparam logic [15:0] MIN_FRAME_LEN  = 16'd42;
  localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
  localparam logic [16:0] FRAME_OVERHEAD = 17'd34;

  typedef enum logic [1:0] {
    OP_BIND   = 2'd0,
    OP_UNBIND = 2'd1,
    OP_DGRAM  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_BOUND     = 3'd2,
    ST_UNBOUND   = 3'd3,
    ST_FULL      = 3'd4,
    ST_MALFORMED = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  // Outcome known already at the front end
  typedef enum logic [1:0] {
    KIND_NORMAL    = 2'd0,
    KIND_MALFORMED = 2'd1,
    KIND_RANGE     = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_CLEAR   = 2'd0,
    BK_IDLE    = 2'd1,
    BK_LOOKUP  = 2'd2,
    BK_DELIVER = 2'd3
  } back_state_t;

  typedef struct packed {
    op_t                 op;
    logic [15:0]         port;
    logic [15:0]         frame_length;
    logic [15:0]         udp_length;
    logic [31:0]         source_ip;
    logic [15:0]         source_port;
    logic [HANDLE_W-1:0] buffer_handle;
    logic [15:0]         max_length;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [31:0]         out_source_ip;
    logic [15:0]         out_source_port;
    logic [15:0]         out_length;
    logic [HANDLE_W-1:0] out_buffer_handle;
  } out_item_t;

  typedef struct packed {
    op_t                 op;
    cmd_kind_t           kind;
    logic [15:0]         port;
    logic [15:0]         payload_length;
    logic [31:0]         source_ip;
    logic [15:0]         source_port;
    logic [HANDLE_W-1:0] handle;
    logic [15:0]         max_length;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cmdq_status_t;

endpackage

@@ rtl/core/udp_port_receive_queues.sv @@
// ----------------------------------------------------------------------------
// udp_port_receive_queues: per-port UDP receive queues
// Binds and unbinds destination ports, queues received datagram descriptors
// per port and pops them on read.
// ----------------------------------------------------------------------------
// Usage
//   Input: drive in_item and raise start; the word is taken at a rising edge
//   where start is high and busy is low. Ops are bind, unbind, received
//   datagram and read.
//   Output: every word gives exactly one result, shown on out_item for one
//   cycle with out_valid high. The receiver cannot stall; results must be
//   taken when strobed.
//   Flow: each word passes the engine's idle and lookup states, and a read
//   that dequeues a descriptor also the deliver state, before its result.
//   The engine finishes one word before it takes the next; this is set by
//   the read-modify-write of the port-state RAM, one read and at most one
//   write per word. A two-word command queue lets the next word in while the
//   engine works.
//   Reset: synchronous, active low. After reset the port table is cleared,
//   one entry a cycle, up to entry PORT_COUNT-1; busy stays high until then.
//   Descriptor storage is not cleared: only counted entries are ever read.
// ----------------------------------------------------------------------------
module udp_port_receive_queues #(
  parameter int unsigned PORT_COUNT     = 64,
  parameter int unsigned QUEUE_CAPACITY = 16,
  parameter int unsigned HANDLE_BITS    = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  upr_pkg::in_item_t  in_item,
  output logic               out_valid,
  output upr_pkg::out_item_t out_item
);

  upr_pkg::cmdq_status_t q_status;
  upr_pkg::cmd_t         push_cmd;
  upr_pkg::cmd_t         q_head;
  logic                  push;
  logic                  pop;
  logic                  clearing;

  // classify and take words
  upr_front #(
    .PORT_COUNT  (PORT_COUNT),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_front (
    .start    (start),
    .in_item  (in_item),
    .q_status (q_status),
    .clearing (clearing),
    .busy     (busy),
    .push     (push),
    .cmd      (push_cmd)
  );

  // hold commands between intake and engine
  upr_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (q_head),
    .status   (q_status)
  );

  // run commands against port state and descriptor store
  upr_back #(
    .PORT_COUNT     (PORT_COUNT),
    .QUEUE_CAPACITY (QUEUE_CAPACITY),
    .HANDLE_BITS    (HANDLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_head    (q_head),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

@@ rtl/core/upr_ram.sv @@
// ----------------------------------------------------------------------------
// upr_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module upr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/upr_front.sv @@
// ----------------------------------------------------------------------------
// upr_front: item intake and classification
// Takes an item when the command queue has room and no table clear runs,
// checks datagram lengths and port range, and forms the back-end command word.
// ----------------------------------------------------------------------------
module upr_front #(
  parameter int unsigned PORT_COUNT  = 64,
  parameter int unsigned HANDLE_BITS = 12
) (
  input  logic                  start,
  input  upr_pkg::in_item_t     in_item,
  input  upr_pkg::cmdq_status_t q_status,
  input  logic                  clearing,
  output logic                  busy,
  output logic                  push,
  output upr_pkg::cmd_t         cmd
);

  localparam int unsigned HW = (HANDLE_BITS < upr_pkg::HANDLE_W) ?
                               HANDLE_BITS : upr_pkg::HANDLE_W;
  localparam logic [upr_pkg::HANDLE_W-1:0] HANDLE_MASK =
    upr_pkg::HANDLE_W'((64'(1) << HW) - 64'(1));
  localparam logic [16:0] PORT_LIMIT = 17'(PORT_COUNT);

  logic malformed;
  logic out_of_range;

  assign busy = clearing | q_status.full;
  assign push = start & ~busy;

  assign malformed = (in_item.frame_length < upr_pkg::MIN_FRAME_LEN) ||
                     (in_item.udp_length < upr_pkg::UDP_HDR_LEN) ||
                     ({1'b0, in_item.frame_length} <
                      (upr_pkg::FRAME_OVERHEAD + {1'b0, in_item.udp_length}));
  assign out_of_range = ({1'b0, in_item.port} >= PORT_LIMIT);

  always_comb begin
    cmd.op             = in_item.op;
    cmd.port           = in_item.port;
    cmd.payload_length = in_item.udp_length - upr_pkg::UDP_HDR_LEN;
    cmd.source_ip      = in_item.source_ip;
    cmd.source_port    = in_item.source_port;
    cmd.handle         = in_item.buffer_handle & HANDLE_MASK;
    cmd.max_length     = in_item.max_length;
    // length checks win over the range check, and apply to datagrams only
    if ((in_item.op == upr_pkg::OP_DGRAM) && malformed) begin
      cmd.kind = upr_pkg::KIND_MALFORMED;
    end else if (out_of_range) begin
      cmd.kind = upr_pkg::KIND_RANGE;
    end else begin
      cmd.kind = upr_pkg::KIND_NORMAL;
    end
  end

endmodule

@@ rtl/core/upr_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// upr_cmd_queue: two-entry command queue
// Decouples the intake from the port-state engine.
// ----------------------------------------------------------------------------
module upr_cmd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  upr_pkg::cmd_t         push_cmd,
  input  logic                  pop,
  output upr_pkg::cmd_t         head,
  output upr_pkg::cmdq_status_t status
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  upr_pkg::cmd_t    entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full  = (count_r == (PTR_W + 1)'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;
  assign head         = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/core/upr_back.sv @@
// ----------------------------------------------------------------------------
// upr_back: port-state engine
// Clears the port table after reset, then runs each command as a
// read-modify-write of the port state and, for a stored datagram or a
// dequeuing read, one descriptor store access. Drives the registered result.
// ----------------------------------------------------------------------------
module upr_back #(
  parameter int unsigned PORT_COUNT     = 64,
  parameter int unsigned QUEUE_CAPACITY = 16,
  parameter int unsigned HANDLE_BITS    = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  upr_pkg::cmdq_status_t q_status,
  input  upr_pkg::cmd_t         q_head,
  output logic                  pop,
  output logic                  clearing,
  output logic                  out_valid,
  output upr_pkg::out_item_t    out_item
);

  localparam int unsigned PW          = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int unsigned HEADW       = (QUEUE_CAPACITY > 1) ? $clog2(QUEUE_CAPACITY) : 1;
  localparam int unsigned CNTW        = $clog2(QUEUE_CAPACITY + 1);
  localparam int unsigned ENTRY_COUNT = PORT_COUNT * QUEUE_CAPACITY;
  localparam int unsigned EW          = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int unsigned HW          = (HANDLE_BITS < upr_pkg::HANDLE_W) ?
                                        HANDLE_BITS : upr_pkg::HANDLE_W;
  localparam int unsigned PST_W       = 1 + HEADW + CNTW;
  localparam int unsigned ENT_W       = 64 + HW;

  upr_pkg::back_state_t state_r, state_nxt;
  logic [PW-1:0]        clr_idx_r, clr_idx_nxt;
  upr_pkg::cmd_t        cmd_r;
  logic [EW-1:0]        base_r, base_nxt;
  logic                 out_valid_r, out_valid_nxt;
  upr_pkg::out_item_t   out_item_r, out_item_nxt;

  // port state RAM
  logic             pst_we, pst_re;
  logic [PW-1:0]    pst_waddr, pst_raddr;
  logic [PST_W-1:0] pst_wdata, pst_rdata;
  logic             pst_bound;
  logic [HEADW-1:0] pst_head;
  logic [CNTW-1:0]  pst_count;

  // descriptor RAM
  logic             ent_we, ent_re;
  logic [EW-1:0]    ent_waddr, ent_raddr;
  logic [ENT_W-1:0] ent_wdata, ent_rdata;
  logic [31:0]      ent_source_ip;
  logic [15:0]      ent_source_port;
  logic [15:0]      ent_length;
  logic [HW-1:0]    ent_handle;

  logic             normal;
  logic             read_hit;
  logic             queue_full;
  logic [CNTW:0]    slot_sum, slot_wrap;
  logic [HEADW-1:0] tail_slot, head_next;

  upr_ram #(.WIDTH(PST_W), .DEPTH(PORT_COUNT)) u_port_ram (
    .clk   (clk),
    .we    (pst_we),
    .waddr (pst_waddr),
    .wdata (pst_wdata),
    .re    (pst_re),
    .raddr (pst_raddr),
    .rdata (pst_rdata)
  );

  upr_ram #(.WIDTH(ENT_W), .DEPTH(ENTRY_COUNT)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign pst_bound = pst_rdata[PST_W-1];
  assign pst_head  = pst_rdata[HEADW+CNTW-1:CNTW];
  assign pst_count = pst_rdata[CNTW-1:0];

  assign ent_source_ip   = ent_rdata[ENT_W-1:ENT_W-32];
  assign ent_source_port = ent_rdata[ENT_W-33:ENT_W-48];
  assign ent_length      = ent_rdata[ENT_W-49:ENT_W-64];
  assign ent_handle      = ent_rdata[HW-1:0];

  assign normal     = (cmd_r.kind == upr_pkg::KIND_NORMAL);
  assign queue_full = (pst_count >= CNTW'(QUEUE_CAPACITY));
  assign read_hit   = normal && (cmd_r.op == upr_pkg::OP_READ) && pst_bound &&
                      (pst_count != '0);

  // tail slot: head plus count, wrapped once
  assign slot_sum  = (CNTW + 1)'(pst_head) + (CNTW + 1)'(pst_count);
  assign slot_wrap = (slot_sum >= (CNTW + 1)'(QUEUE_CAPACITY)) ?
                     slot_sum - (CNTW + 1)'(QUEUE_CAPACITY) : slot_sum;
  assign tail_slot = HEADW'(slot_wrap);
  assign head_next = (pst_head == HEADW'(QUEUE_CAPACITY - 1)) ? '0 : pst_head + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      upr_pkg::BK_CLEAR: begin
        if (clr_idx_r == PW'(PORT_COUNT - 1)) begin
          state_nxt = upr_pkg::BK_IDLE;
        end
      end
      upr_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          state_nxt = upr_pkg::BK_LOOKUP;
        end
      end
      upr_pkg::BK_LOOKUP: begin
        state_nxt = read_hit ? upr_pkg::BK_DELIVER : upr_pkg::BK_IDLE;
      end
      upr_pkg::BK_DELIVER: begin
        state_nxt = upr_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = upr_pkg::BK_CLEAR;
      end
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    clearing      = 1'b0;
    pop           = 1'b0;
    clr_idx_nxt   = clr_idx_r;
    base_nxt      = base_r;
    pst_we        = 1'b0;
    pst_waddr     = cmd_r.port[PW-1:0];
    pst_wdata     = '0;
    pst_re        = 1'b0;
    pst_raddr     = q_head.port[PW-1:0];
    ent_we        = 1'b0;
    ent_waddr     = base_r + EW'(tail_slot);
    ent_wdata     = {cmd_r.source_ip, cmd_r.source_port, cmd_r.payload_length,
                     cmd_r.handle[HW-1:0]};
    ent_re        = 1'b0;
    ent_raddr     = base_r + EW'(pst_head);
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    case (state_r)
      upr_pkg::BK_CLEAR: begin
        clearing    = 1'b1;
        pst_we      = 1'b1;
        pst_waddr   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
      upr_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          pop      = 1'b1;
          pst_re   = 1'b1;
          base_nxt = EW'(q_head.port[PW-1:0]) * EW'(QUEUE_CAPACITY);
        end
      end
      upr_pkg::BK_LOOKUP: begin
        out_valid_nxt = !read_hit;
        if (cmd_r.kind == upr_pkg::KIND_MALFORMED) begin
          out_item_nxt.status            = upr_pkg::ST_MALFORMED;
          out_item_nxt.out_buffer_handle = cmd_r.handle;
        end else if (cmd_r.kind == upr_pkg::KIND_RANGE) begin
          out_item_nxt.status = upr_pkg::ST_RANGE;
          if (cmd_r.op == upr_pkg::OP_DGRAM) begin
            out_item_nxt.out_buffer_handle = cmd_r.handle;
          end
        end else begin
          case (cmd_r.op)
            upr_pkg::OP_BIND: begin
              if (pst_bound) begin
                out_item_nxt.status = upr_pkg::ST_BOUND;
              end else begin
                pst_we    = 1'b1;
                pst_wdata = {1'b1, HEADW'(0), CNTW'(0)};
              end
            end
            upr_pkg::OP_UNBIND: begin
              if (!pst_bound) begin
                out_item_nxt.status = upr_pkg::ST_UNBOUND;
              end else begin
                pst_we = 1'b1;
              end
            end
            upr_pkg::OP_DGRAM: begin
              if (!pst_bound) begin
                out_item_nxt.status            = upr_pkg::ST_UNBOUND;
                out_item_nxt.out_buffer_handle = cmd_r.handle;
              end else if (queue_full) begin
                out_item_nxt.status            = upr_pkg::ST_FULL;
                out_item_nxt.out_buffer_handle = cmd_r.handle;
              end else begin
                ent_we    = 1'b1;
                pst_we    = 1'b1;
                pst_wdata = {1'b1, pst_head, pst_count + 1'b1};
              end
            end
            upr_pkg::OP_READ: begin
              if (!pst_bound) begin
                out_item_nxt.status = upr_pkg::ST_UNBOUND;
              end else if (pst_count == '0) begin
                out_item_nxt.status = upr_pkg::ST_EMPTY;
              end else begin
                ent_re    = 1'b1;
                pst_we    = 1'b1;
                pst_wdata = {1'b1, head_next, pst_count - 1'b1};
              end
            end
            default: begin
              out_item_nxt = '0;
            end
          endcase
        end
      end
      upr_pkg::BK_DELIVER: begin
        out_valid_nxt                  = 1'b1;
        out_item_nxt.status            = upr_pkg::ST_OK;
        out_item_nxt.out_source_ip     = ent_source_ip;
        out_item_nxt.out_source_port   = ent_source_port;
        out_item_nxt.out_length        = (ent_length < cmd_r.max_length) ?
                                         ent_length : cmd_r.max_length;
        out_item_nxt.out_buffer_handle = upr_pkg::HANDLE_W'(ent_handle);
      end
      default: begin
        clearing = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= upr_pkg::BK_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= q_head;
    end
    base_r     <= base_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/core/upr_checker.sv @@
// ----------------------------------------------------------------------------
// upr_checker: port-level checks for udp_port_receive_queues
// Watches reset behaviour, result spacing and result word contents.
// ----------------------------------------------------------------------------
module upr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_valid,
  input upr_pkg::out_item_t out_item
);

  // table clearing holds off input right after reset
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low in the cycle after reset");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobed right after reset");

  // the engine returns to idle after every result
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results strobed in consecutive cycles");

  // only a successful read carries address, port and length
  a_plain_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != upr_pkg::ST_OK)) |->
      ((out_item.out_source_ip == 32'd0) && (out_item.out_source_port == 16'd0) &&
       (out_item.out_length == 16'd0)))
    else $error("non-ok result carries descriptor fields");

endmodule

bind udp_port_receive_queues upr_checker u_upr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

@@ bench/upr_result_checker.sv @@
// ----------------------------------------------------------------------------
// upr_result_checker: outcome predictor and comparator for the port queues
// Watches the word and result channels of udp_port_receive_queues, keeps its
// own copy of the port table and descriptor store, and checks every result.
// ----------------------------------------------------------------------------
module upr_result_checker #(
  parameter int unsigned PORT_COUNT     = 64,
  parameter int unsigned QUEUE_CAPACITY = 16,
  parameter int unsigned HANDLE_BITS    = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  upr_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  upr_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending
);

  localparam int unsigned ENTRIES = PORT_COUNT * QUEUE_CAPACITY;
  localparam logic [upr_pkg::HANDLE_W-1:0] HANDLE_MASK =
    upr_pkg::HANDLE_W'((64'd1 << HANDLE_BITS) - 64'd1);
  localparam int PRINT_CAP = 40;

  logic                         bound_flag [PORT_COUNT];
  int unsigned                  q_head     [PORT_COUNT];
  int unsigned                  q_fill     [PORT_COUNT];
  logic [31:0]                  entry_ip     [ENTRIES];
  logic [15:0]                  entry_sport  [ENTRIES];
  logic [15:0]                  entry_len    [ENTRIES];
  logic [upr_pkg::HANDLE_W-1:0] entry_handle [ENTRIES];

  upr_pkg::out_item_t awaited_outcomes [$];

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= PRINT_CAP) $display("%0t: mismatch: %s", $time, msg);
  endtask

  // Apply one word to the port table and return the result it must give
  function automatic upr_pkg::out_item_t port_queue_outcome(input upr_pkg::in_item_t w);
    upr_pkg::out_item_t r;
    int unsigned p;
    int unsigned slot;
    int unsigned idx;
    r = '0;
    p = 32'(w.port);
    if (w.op == upr_pkg::OP_DGRAM) begin
      r.out_buffer_handle = w.buffer_handle & HANDLE_MASK;
      if (w.frame_length < upr_pkg::MIN_FRAME_LEN || w.udp_length < upr_pkg::UDP_HDR_LEN ||
          int'(w.frame_length) < int'(upr_pkg::FRAME_OVERHEAD) + int'(w.udp_length)) begin
        r.status = upr_pkg::ST_MALFORMED;
      end else if (p >= PORT_COUNT) begin
        r.status = upr_pkg::ST_RANGE;
      end else if (!bound_flag[p]) begin
        r.status = upr_pkg::ST_UNBOUND;
      end else if (q_fill[p] >= QUEUE_CAPACITY) begin
        r.status = upr_pkg::ST_FULL;
      end else begin
        slot = (q_head[p] + q_fill[p]) % QUEUE_CAPACITY;
        idx  = p * QUEUE_CAPACITY + slot;
        entry_ip[idx]     = w.source_ip;
        entry_sport[idx]  = w.source_port;
        entry_len[idx]    = w.udp_length - upr_pkg::UDP_HDR_LEN;
        entry_handle[idx] = w.buffer_handle & HANDLE_MASK;
        q_fill[p]++;
        r = '0;
      end
      return r;
    end
    if (p >= PORT_COUNT) begin
      r.status = upr_pkg::ST_RANGE;
      return r;
    end
    case (w.op)
      upr_pkg::OP_BIND: begin
        if (bound_flag[p]) begin
          r.status = upr_pkg::ST_BOUND;
        end else begin
          bound_flag[p] = 1'b1;
          q_head[p]     = 0;
          q_fill[p]     = 0;
        end
      end
      upr_pkg::OP_UNBIND: begin
        if (!bound_flag[p]) begin
          r.status = upr_pkg::ST_UNBOUND;
        end else begin
          bound_flag[p] = 1'b0;
          q_head[p]     = 0;
          q_fill[p]     = 0;
        end
      end
      upr_pkg::OP_READ: begin
        if (!bound_flag[p]) begin
          r.status = upr_pkg::ST_UNBOUND;
        end else if (q_fill[p] == 0) begin
          r.status = upr_pkg::ST_EMPTY;
        end else begin
          slot = q_head[p] % QUEUE_CAPACITY;
          idx  = p * QUEUE_CAPACITY + slot;
          r.out_source_ip     = entry_ip[idx];
          r.out_source_port   = entry_sport[idx];
          r.out_length        = (entry_len[idx] > w.max_length) ? w.max_length
                                                                : entry_len[idx];
          r.out_buffer_handle = entry_handle[idx];
          q_head[p] = (slot + 1) % QUEUE_CAPACITY;
          q_fill[p]--;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    upr_pkg::out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        bound_flag[i] = 1'b0;
        q_head[i]     = 0;
        q_fill[i]     = 0;
      end
      awaited_outcomes.delete();
      fail_count = 0;
    end else begin
      // compare before taking the new word: a result never belongs to the
      // word accepted at the same edge
      if (out_valid) begin
        if (awaited_outcomes.size() == 0) begin
          report_mismatch($sformatf("result with nothing awaited, status %0d",
                                    out_item.status));
        end else begin
          want = awaited_outcomes.pop_front();
          if (out_item.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_item.status, want.status));
          if (out_item.out_source_ip !== want.out_source_ip)
            report_mismatch($sformatf("source ip %h, expected %h",
                                      out_item.out_source_ip, want.out_source_ip));
          if (out_item.out_source_port !== want.out_source_port)
            report_mismatch($sformatf("source port %h, expected %h",
                                      out_item.out_source_port, want.out_source_port));
          if (out_item.out_length !== want.out_length)
            report_mismatch($sformatf("length %h, expected %h",
                                      out_item.out_length, want.out_length));
          if (out_item.out_buffer_handle !== want.out_buffer_handle)
            report_mismatch($sformatf("handle %h, expected %h",
                                      out_item.out_buffer_handle,
                                      want.out_buffer_handle));
        end
      end
      if (start && !busy) awaited_outcomes.push_back(port_queue_outcome(in_item));
    end
    pending = awaited_outcomes.size();
  end

endmodule

@@ bench/udp_port_receive_queues_test.sv @@
// ----------------------------------------------------------------------------
// udp_port_receive_queues_test: top level of the port receive queue bench
// Drives bind, unbind, datagram and read words in random bursts, lets a
// side checker predict and compare every result, and gives the verdict.
// ----------------------------------------------------------------------------
module udp_port_receive_queues_test;

  localparam int unsigned PORT_COUNT     = 64;
  localparam int unsigned QUEUE_CAPACITY = 16;
  localparam int unsigned HANDLE_BITS    = 12;

  localparam int ITEM_TARGET = 850;
  // Longest quiet stretch of a correct run is the reset plus the table clear
  // or one sender gap; take that many times over.
  localparam int IDLE_LIMIT  = 4000;
  // Wait a little past the drain for stray results.
  localparam int TAIL_CYCLES = 10;

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               start   = 1'b0;
  upr_pkg::in_item_t  in_item = '0;
  logic               busy;
  logic               out_valid;
  upr_pkg::out_item_t out_item;
  int                 fail_count;
  int                 pending;

  int items_sent = 0;
  int burst_left = 0;

  // Few ports carry most traffic so that queues fill and wrap
  logic [15:0] hot_ports [4] = '{16'd0, 16'd21, 16'd42, 16'(PORT_COUNT - 1)};

  always #6 clk = ~clk;

  udp_port_receive_queues #(
    .PORT_COUNT     (PORT_COUNT),
    .QUEUE_CAPACITY (QUEUE_CAPACITY),
    .HANDLE_BITS    (HANDLE_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  upr_result_checker #(
    .PORT_COUNT     (PORT_COUNT),
    .QUEUE_CAPACITY (QUEUE_CAPACITY),
    .HANDLE_BITS    (HANDLE_BITS)
  ) result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Every field random, fields the op ignores included
  function automatic upr_pkg::in_item_t random_word();
    upr_pkg::in_item_t w;
    w.op            = upr_pkg::op_t'($urandom_range(0, 3));
    w.port          = 16'($urandom);
    w.frame_length  = 16'($urandom);
    w.udp_length    = 16'($urandom);
    w.source_ip     = $urandom;
    w.source_port   = 16'($urandom);
    w.buffer_handle = upr_pkg::HANDLE_W'($urandom);
    w.max_length    = 16'($urandom);
    return w;
  endfunction

  function automatic logic [15:0] hot_port();
    if ($urandom_range(0, 6) == 0) return 16'($urandom_range(0, PORT_COUNT - 1));
    return hot_ports[$urandom_range(0, 3)];
  endfunction

  // Word for one op on one port; reads get a spread of reader limits
  function automatic upr_pkg::in_item_t port_word(input upr_pkg::op_t op,
                                                  input logic [15:0] port);
    upr_pkg::in_item_t w;
    w      = random_word();
    w.op   = op;
    w.port = port;
    if (op == upr_pkg::OP_READ) begin
      case ($urandom_range(0, 3))
        0:       w.max_length = '1;
        1:       w.max_length = 16'($urandom_range(0, 64));
        default: ;
      endcase
    end
    return w;
  endfunction

  function automatic upr_pkg::in_item_t dgram_word(input logic [15:0] port,
                                                   input logic [15:0] frame_len,
                                                   input logic [15:0] udp_len);
    upr_pkg::in_item_t w;
    w              = port_word(upr_pkg::OP_DGRAM, port);
    w.frame_length = frame_len;
    w.udp_length   = udp_len;
    return w;
  endfunction

  // Well-formed datagram: half short payloads, half across the full range
  function automatic upr_pkg::in_item_t random_datagram(input logic [15:0] port);
    int udp_len;
    int lo;
    udp_len = ($urandom_range(0, 1) == 0) ? $urandom_range(8, 200)
                                          : $urandom_range(8, 65501);
    lo = (udp_len + 34 < 42) ? 42 : udp_len + 34;
    return dgram_word(port,
                      16'($urandom_range(lo, ($urandom_range(0, 1) == 0) ?
                                              ((lo + 64 > 65535) ? 65535 : lo + 64) :
                                              65535)),
                      16'(udp_len));
  endfunction

  // Datagram that fails one of the length checks
  function automatic upr_pkg::in_item_t malformed_datagram(input logic [15:0] port);
    int udp_len;
    case ($urandom_range(0, 2))
      0: return dgram_word(port, 16'($urandom_range(0, 41)), 16'($urandom));
      1: return dgram_word(port, 16'($urandom), 16'($urandom_range(0, 7)));
      default: begin
        udp_len = $urandom_range(8, 65501);
        return dgram_word(port, 16'($urandom_range(0, udp_len + 33)), 16'(udp_len));
      end
    endcase
  endfunction

  // Hand one word over; open a new burst after a random gap, which may be
  // zero, when the last one has run out. Hold start high across a burst.
  task automatic send_word(input upr_pkg::in_item_t w);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Hold off the sender until every awaited result has come back.
  // Sample the checker's counters at the falling edge to stay clear of it.
  task automatic wait_until_drained();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    burst_left = 0;
  endtask

  initial begin : stimulus
    upr_pkg::in_item_t w;
    logic [15:0] p;
    int r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: unbound port, bind twice, range checks, the three
    // malformed cases (ahead of the port check), length extremes, reads
    // with and without a limit, empty queue, unbind clearing a queue.
    send_word(port_word(upr_pkg::OP_READ, 16'd0));
    send_word(port_word(upr_pkg::OP_UNBIND, 16'd0));
    send_word(dgram_word(16'd0, 16'd100, 16'd20));
    send_word(port_word(upr_pkg::OP_BIND, 16'd0));
    send_word(port_word(upr_pkg::OP_BIND, 16'd0));
    send_word(port_word(upr_pkg::OP_BIND, 16'(PORT_COUNT - 1)));
    send_word(port_word(upr_pkg::OP_BIND, 16'(PORT_COUNT)));
    send_word(port_word(upr_pkg::OP_UNBIND, 16'hFFFF));
    send_word(port_word(upr_pkg::OP_READ, 16'(PORT_COUNT)));
    send_word(dgram_word(16'hFFFF, 16'd100, 16'd20));
    send_word(dgram_word(16'd0, 16'd41, 16'd8));
    send_word(dgram_word(16'd0, 16'd42, 16'd7));
    send_word(dgram_word(16'hFFFF, 16'd100, 16'd67));
    w = dgram_word(16'd0, 16'd42, 16'd8);
    w.source_ip     = '0;
    w.source_port   = '0;
    w.buffer_handle = '0;
    send_word(w);
    w = dgram_word(16'(PORT_COUNT - 1), 16'hFFFF, 16'd65501);
    w.source_ip     = '1;
    w.source_port   = '1;
    w.buffer_handle = '1;
    send_word(w);
    send_word(dgram_word(16'd0, 16'd75, 16'd41));
    w = port_word(upr_pkg::OP_READ, 16'd0);
    w.max_length = '1;
    send_word(w);
    w = port_word(upr_pkg::OP_READ, 16'd0);
    w.max_length = '0;
    send_word(w);
    send_word(port_word(upr_pkg::OP_READ, 16'd0));
    w = port_word(upr_pkg::OP_READ, 16'(PORT_COUNT - 1));
    w.max_length = '1;
    send_word(w);
    send_word(random_datagram(16'(PORT_COUNT - 1)));
    send_word(port_word(upr_pkg::OP_UNBIND, 16'(PORT_COUNT - 1)));
    send_word(port_word(upr_pkg::OP_READ, 16'(PORT_COUNT - 1)));
    send_word(port_word(upr_pkg::OP_BIND, 16'(PORT_COUNT - 1)));
    send_word(port_word(upr_pkg::OP_READ, 16'(PORT_COUNT - 1)));
    wait_until_drained();

    // Random part: fill-and-drain runs that overflow and wrap a queue,
    // mixed traffic on the hot ports, and a little noise
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) begin
        p = hot_port();
        send_word(port_word(upr_pkg::OP_BIND, p));
        repeat ($urandom_range(QUEUE_CAPACITY - 1, QUEUE_CAPACITY + 2))
          send_word(random_datagram(p));
        repeat ($urandom_range(QUEUE_CAPACITY - 4, QUEUE_CAPACITY + 2))
          send_word(port_word(upr_pkg::OP_READ, p));
      end else begin
        repeat ($urandom_range(10, 30)) begin
          r = $urandom_range(0, 99);
          if (r < 8)       send_word(port_word(upr_pkg::OP_BIND, hot_port()));
          else if (r < 13) send_word(port_word(upr_pkg::OP_UNBIND, hot_port()));
          else if (r < 55) send_word(random_datagram(hot_port()));
          else if (r < 90) send_word(port_word(upr_pkg::OP_READ, hot_port()));
          else if (r < 95) send_word(random_word());
          else             send_word(malformed_datagram(hot_port()));
        end
      end
      if ($urandom_range(0, 7) == 0) wait_until_drained();
    end

    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Abandon the run when neither a word nor a result moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) quiet = 0;
      else                               quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/upr_pkg.sv
rtl/core/upr_ram.sv
rtl/core/upr_front.sv
rtl/core/upr_cmd_queue.sv
rtl/core/upr_back.sv
rtl/core/udp_port_receive_queues.sv
rtl/core/upr_checker.sv
bench/upr_result_checker.sv
bench/udp_port_receive_queues_test.sv
